[hw/rtl/sawc_pkg.sv]
// ----------------------------------------------------------------------------
// sawc_pkg
// Shared types and constants of the set-associative write-back cache.
// ----------------------------------------------------------------------------
package sawc_pkg;

  // Access kinds on the op field.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WAYS     = 2'd0;
  localparam logic [1:0] CFG_BLOCK    = 2'd1;
  localparam logic [1:0] CFG_CAPACITY = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [1:0] WAYS_LOG2_RST     = 2'd0;
  localparam logic [2:0] BLOCK_LOG2_RST    = 3'd5;
  localparam logic [3:0] CAPACITY_LOG2_RST = 4'd12;

  // Geometry limits that do not move with the parameters.
  localparam int BLOCK_LOG2_MAX    = 6;
  localparam int CAPACITY_LOG2_MIN = 8;
  localparam int BLOCK_BYTES_MAX   = 64;
  localparam int KCNT_W            = $clog2(BLOCK_BYTES_MAX + 1);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WB,
    ST_FILL,
    ST_TOUCH,
    ST_DATA,
    ST_RDWAIT,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/set_assoc_writeback_cache.sv]
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache
// Byte-wide set-associative write-back, write-allocate cache with true LRU
// replacement in front of a modelled main memory.
// ----------------------------------------------------------------------------
// One access is worked at a time by a sequencer around three single-port
// style memories (line metadata, cache data, main memory), each with a
// registered read. An access steps through these states: the tag scan reads
// one way of the set per cycle and drains the read pipeline, the victim
// decision picks a way, the recency update writes one way per cycle, the
// data access writes the byte for a write or reads it with one extra wait
// state for a read, and the result register is loaded once the output is
// free. A miss adds the fill and, for a dirty victim, a write-back before
// it, as blocks move one byte per cycle through the memory ports. The next
// input is taken the cycle after the result is loaded. After reset the
// block sweeps the larger of main memory and the line metadata, one entry
// per cycle, before it takes an input; a configuration write sweeps the
// metadata only and discards any dirty data not yet written back.
module set_assoc_writeback_cache #(
  parameter int ADDR_BITS       = 16,
  parameter int MAX_WAYS        = 8,
  parameter int MAX_CAPACITY    = 16384,
  parameter int MIN_BLOCK_BYTES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [7:0]           write_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           read_data,
  output logic                 hit,
  output logic                 wrote_back,
  output logic [31:0]          hit_total,
  output logic [31:0]          miss_total,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [3:0]           cfg_data
);

  localparam int LINES     = MAX_CAPACITY / MIN_BLOCK_BYTES;
  localparam int LINE_W    = $clog2(LINES);
  localparam int DATA_W    = $clog2(MAX_CAPACITY);
  localparam int MEM_BYTES = 1 << ADDR_BITS;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int AGE_W     = WAY_W;
  localparam int META_W    = 2 + AGE_W + ADDR_BITS;
  localparam int BMIN_RAW  = $clog2(MIN_BLOCK_BYTES);
  localparam int BMIN      = (BMIN_RAW > sawc_pkg::BLOCK_LOG2_MAX) ?
                             sawc_pkg::BLOCK_LOG2_MAX : BMIN_RAW;
  localparam int CMAX      = $clog2(MAX_CAPACITY + 1) - 1;
  localparam int WMAX      = $clog2(MAX_WAYS + 1) - 1;
  localparam int CLR_N     = (LINES > MEM_BYTES) ? LINES : MEM_BYTES;
  localparam int CLR_W     = $clog2(CLR_N + 1);
  localparam int KW        = sawc_pkg::KCNT_W;

  // Configuration registers.
  logic [1:0] ways_log2;
  logic [2:0] block_log2;
  logic [3:0] capacity_log2;
  logic       cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == sawc_pkg::CFG_WAYS ||
                              cfg_index == sawc_pkg::CFG_BLOCK ||
                              cfg_index == sawc_pkg::CFG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_log2     <= sawc_pkg::WAYS_LOG2_RST;
      block_log2    <= sawc_pkg::BLOCK_LOG2_RST;
      capacity_log2 <= sawc_pkg::CAPACITY_LOG2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sawc_pkg::CFG_WAYS:     ways_log2     <= cfg_data[1:0];
        sawc_pkg::CFG_BLOCK:    block_log2    <= cfg_data[2:0];
        sawc_pkg::CFG_CAPACITY: capacity_log2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry: clamp the registers into a legal shape.
  logic [4:0] g_w, g_b, g_sl, g_tsh;

  always_comb begin
    logic [4:0] w0, b0, c0;
    w0 = {3'b0, ways_log2};
    if (w0 > 5'(WMAX)) w0 = 5'(WMAX);
    b0 = {2'b0, block_log2};
    if (b0 < 5'(BMIN)) b0 = 5'(BMIN);
    if (b0 > 5'(sawc_pkg::BLOCK_LOG2_MAX)) b0 = 5'(sawc_pkg::BLOCK_LOG2_MAX);
    c0 = {1'b0, capacity_log2};
    if (c0 < 5'(sawc_pkg::CAPACITY_LOG2_MIN)) c0 = 5'(sawc_pkg::CAPACITY_LOG2_MIN);
    if (c0 < b0 + w0) c0 = b0 + w0;
    if (c0 > 5'(CMAX)) c0 = 5'(CMAX);
    if (b0 + w0 > c0) w0 = (c0 >= b0) ? c0 - b0 : 5'd0;
    if (b0 + w0 > c0) b0 = c0 - w0;
    g_w   = w0;
    g_b   = b0;
    g_sl  = c0 - b0 - w0;
    g_tsh = c0 - w0;
  end

  logic [WCNT_W-1:0] ways_n;
  logic [KW-1:0]     bsize_n;
  assign ways_n  = WCNT_W'(1) << g_w;
  assign bsize_n = KW'(1) << g_b;

  // Memories and their ports.
  logic [META_W-1:0]    meta_mem [LINES];
  logic [7:0]           data_mem [MAX_CAPACITY];
  logic [7:0]           main_mem [MEM_BYTES];
  logic                 meta_we, data_we, main_we;
  logic [LINE_W-1:0]    meta_waddr, meta_raddr;
  logic [META_W-1:0]    meta_wdata, meta_q;
  logic [DATA_W-1:0]    data_waddr, data_raddr;
  logic [7:0]           data_wdata, data_q;
  logic [ADDR_BITS-1:0] main_waddr, main_raddr;
  logic [7:0]           main_wdata, main_q;

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    meta_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_waddr] <= data_wdata;
    data_q <= data_mem[data_raddr];
  end

  always_ff @(posedge clk) begin
    if (main_we) main_mem[main_waddr] <= main_wdata;
    main_q <= main_mem[main_raddr];
  end

  // Sequencer and datapath registers.
  sawc_pkg::state_t state, state_next;

  logic [CLR_W-1:0]     cnt;
  logic                 clear_main;
  logic [WCNT_W-1:0]    wcnt;
  logic [KW-1:0]        kcnt;
  logic                 pv;
  logic [WAY_W-1:0]     pway;
  logic [KW-1:0]        pk;

  logic                 op_q;
  logic [7:0]           wdata_q;
  logic [5:0]           off_q;
  logic [LINE_W-1:0]    set_q;
  logic [ADDR_BITS-1:0] tag_q, faddr_q;

  logic                 cv [MAX_WAYS];
  logic                 cd [MAX_WAYS];
  logic [AGE_W-1:0]     ca [MAX_WAYS];
  logic [ADDR_BITS-1:0] ct [MAX_WAYS];

  logic                 hit_f, hit_dirty, inv_f, lru_f, lru_dirty, wb_flag;
  logic [WAY_W-1:0]     hit_way, inv_way, lru_way, sel_way;
  logic [AGE_W-1:0]     hit_age, lru_age;
  logic [ADDR_BITS-1:0] lru_tag;
  logic [WCNT_W-1:0]    old_age;
  logic [7:0]           rd_val;
  logic [31:0]          hit_counter, miss_counter;

  // Address split of the incoming beat.
  logic [31:0]          a_shift;
  logic [LINE_W-1:0]    a_set;
  logic [ADDR_BITS-1:0] a_off_full;
  assign a_shift    = 32'(address) >> g_b;
  assign a_set      = LINE_W'(a_shift & ~(32'hFFFF_FFFF << g_sl));
  assign a_off_full = address & ~({ADDR_BITS{1'b1}} << g_b);

  // Line and byte addresses of the access in flight.
  logic [LINE_W-1:0]    base, sel_line;
  logic [DATA_W-1:0]    dbase;
  logic [ADDR_BITS-1:0] vaddr;
  assign base     = LINE_W'(32'(set_q) << g_w);
  assign sel_line = base | LINE_W'(sel_way);
  assign dbase    = DATA_W'(32'(sel_line) << g_b);
  assign vaddr    = ADDR_BITS'((32'(lru_tag) << g_tsh) | (32'(set_q) << g_b));

  // Fields of the metadata word coming back from the tag scan.
  logic                 m_v, m_d;
  logic [AGE_W-1:0]     m_a;
  logic [ADDR_BITS-1:0] m_t;
  assign m_v = meta_q[META_W-1];
  assign m_d = meta_q[META_W-2];
  assign m_a = meta_q[ADDR_BITS +: AGE_W];
  assign m_t = meta_q[ADDR_BITS-1:0];

  logic             out_free, issue_way, issue_byte;
  logic [WAY_W-1:0] tidx;
  logic [AGE_W-1:0] t_age;
  assign out_free   = !out_valid || !out_stall;
  assign issue_way  = wcnt < ways_n;
  assign issue_byte = kcnt < bsize_n;
  assign tidx       = wcnt[WAY_W-1:0];
  assign t_age      = (cv[tidx] && {{(WCNT_W-AGE_W){1'b0}}, ca[tidx]} < old_age) ?
                      ca[tidx] + AGE_W'(1) : ca[tidx];
  assign in_stall   = (state != sawc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= sawc_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    meta_we    = 1'b0;
    meta_waddr = base | LINE_W'(tidx);
    meta_wdata = '0;
    meta_raddr = base | LINE_W'(tidx);
    data_we    = 1'b0;
    data_waddr = dbase | DATA_W'(pk);
    data_wdata = main_q;
    data_raddr = dbase | DATA_W'(kcnt);
    main_we    = 1'b0;
    main_waddr = vaddr | ADDR_BITS'(pk);
    main_wdata = data_q;
    main_raddr = faddr_q | ADDR_BITS'(kcnt);
    unique case (state)
      sawc_pkg::ST_CLEAR: begin
        meta_waddr = cnt[LINE_W-1:0];
        main_waddr = cnt[ADDR_BITS-1:0];
        main_wdata = '0;
        meta_we    = cnt < CLR_W'(LINES);
        main_we    = clear_main && cnt < CLR_W'(MEM_BYTES);
        if (!meta_we && !main_we) state_next = sawc_pkg::ST_IDLE;
      end
      sawc_pkg::ST_IDLE: begin
        if (in_valid) state_next = sawc_pkg::ST_SCAN;
      end
      sawc_pkg::ST_SCAN: begin
        if (!issue_way && !pv) state_next = sawc_pkg::ST_DECIDE;
      end
      sawc_pkg::ST_DECIDE: begin
        if (hit_f)                         state_next = sawc_pkg::ST_TOUCH;
        else if (!inv_f && lru_dirty)      state_next = sawc_pkg::ST_WB;
        else                               state_next = sawc_pkg::ST_FILL;
      end
      sawc_pkg::ST_WB: begin
        main_we = pv;
        if (!issue_byte && !pv) state_next = sawc_pkg::ST_FILL;
      end
      sawc_pkg::ST_FILL: begin
        data_we = pv;
        if (!issue_byte && !pv) state_next = sawc_pkg::ST_TOUCH;
      end
      sawc_pkg::ST_TOUCH: begin
        meta_we = 1'b1;
        if (tidx == sel_way) begin
          meta_wdata = {1'b1, (op_q == sawc_pkg::OP_WRITE) || (hit_f && hit_dirty),
                        {AGE_W{1'b0}}, tag_q};
        end else begin
          meta_wdata = {cv[tidx], cd[tidx], t_age, ct[tidx]};
        end
        if (wcnt == ways_n - WCNT_W'(1)) state_next = sawc_pkg::ST_DATA;
      end
      sawc_pkg::ST_DATA: begin
        data_waddr = dbase | DATA_W'(off_q);
        data_raddr = dbase | DATA_W'(off_q);
        data_wdata = wdata_q;
        if (op_q == sawc_pkg::OP_WRITE) begin
          data_we    = 1'b1;
          state_next = sawc_pkg::ST_DONE;
        end else begin
          state_next = sawc_pkg::ST_RDWAIT;
        end
      end
      sawc_pkg::ST_RDWAIT: begin
        state_next = sawc_pkg::ST_DONE;
      end
      sawc_pkg::ST_DONE: begin
        if (out_free) state_next = sawc_pkg::ST_IDLE;
      end
      default: state_next = sawc_pkg::ST_CLEAR;
    endcase
    // A configuration write invalidates every line.
    if (cfg_hit) state_next = sawc_pkg::ST_CLEAR;
  end

  // Sweep counter and main-memory clear flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      clear_main <= 1'b1;
    end else if (cfg_hit) begin
      cnt <= '0;
    end else if (state == sawc_pkg::ST_CLEAR) begin
      cnt <= cnt + CLR_W'(1);
      if (state_next == sawc_pkg::ST_IDLE) clear_main <= 1'b0;
    end
  end

  // Way and byte counters with the valid tag of the registered read.
  always_ff @(posedge clk) begin
    if (rst || state != state_next) begin
      wcnt <= '0;
      kcnt <= '0;
      pv   <= 1'b0;
    end else begin
      case (state) inside
        sawc_pkg::ST_SCAN: begin
          if (issue_way) wcnt <= wcnt + WCNT_W'(1);
          pv   <= issue_way;
          pway <= tidx;
        end
        sawc_pkg::ST_WB, sawc_pkg::ST_FILL: begin
          if (issue_byte) kcnt <= kcnt + KW'(1);
          pv <= issue_byte;
          pk <= kcnt;
        end
        sawc_pkg::ST_TOUCH: wcnt <= wcnt + WCNT_W'(1);
        default: ;
      endcase
    end
  end

  // Access capture, tag scan bookkeeping and the victim decision.
  always_ff @(posedge clk) begin
    if (state == sawc_pkg::ST_IDLE && in_valid) begin
      op_q    <= op;
      wdata_q <= write_data;
      off_q   <= a_off_full[5:0];
      set_q   <= a_set;
      tag_q   <= ADDR_BITS'(32'(address) >> g_tsh);
      faddr_q <= address & ({ADDR_BITS{1'b1}} << g_b);
      hit_f   <= 1'b0;
      inv_f   <= 1'b0;
      lru_f   <= 1'b0;
    end
    if (state == sawc_pkg::ST_SCAN && pv) begin
      cv[pway] <= m_v;
      cd[pway] <= m_d;
      ca[pway] <= m_a;
      ct[pway] <= m_t;
      if (!hit_f && m_v && m_t == tag_q) begin
        hit_f     <= 1'b1;
        hit_way   <= pway;
        hit_age   <= m_a;
        hit_dirty <= m_d;
      end
      if (!inv_f && !m_v) begin
        inv_f   <= 1'b1;
        inv_way <= pway;
      end
      // Oldest valid way, lowest way number among equal ages.
      if (m_v && (!lru_f || m_a > lru_age)) begin
        lru_f     <= 1'b1;
        lru_way   <= pway;
        lru_age   <= m_a;
        lru_tag   <= m_t;
        lru_dirty <= m_d;
      end
    end
    if (state == sawc_pkg::ST_DECIDE) begin
      if (hit_f) begin
        sel_way <= hit_way;
        old_age <= WCNT_W'(hit_age);
      end else if (inv_f) begin
        sel_way <= inv_way;
        old_age <= ways_n;
      end else begin
        sel_way <= lru_way;
        old_age <= WCNT_W'(lru_age);
      end
      wb_flag <= !hit_f && !inv_f && lru_dirty;
    end
    if (state == sawc_pkg::ST_DATA) rd_val <= wdata_q;
    if (state == sawc_pkg::ST_RDWAIT) rd_val <= data_q;
  end

  // Output register and running counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      hit_counter  <= '0;
      miss_counter <= '0;
    end else if (state == sawc_pkg::ST_DONE && out_free) begin
      out_valid  <= 1'b1;
      read_data  <= rd_val;
      hit        <= hit_f;
      wrote_back <= wb_flag;
      hit_total  <= hit_counter + 32'(hit_f);
      miss_total <= miss_counter + 32'(!hit_f);
      if (hit_f) hit_counter  <= hit_counter + 32'd1;
      else       miss_counter <= miss_counter + 32'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/sawc_checker.sv]
// ----------------------------------------------------------------------------
// sawc_checker
// Port-level assertions for the set-associative write-back cache.
// ----------------------------------------------------------------------------
module sawc_checker #(
  parameter int ADDR_BITS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 op,
  input logic [ADDR_BITS-1:0] address,
  input logic [7:0]           write_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [7:0]           read_data,
  input logic                 hit,
  input logic                 wrote_back,
  input logic [31:0]          hit_total,
  input logic [31:0]          miss_total,
  input logic                 cfg_we,
  input logic [1:0]           cfg_index,
  input logic [3:0]           cfg_data
);

  // Sum of the counters at the previous result beat.
  logic [31:0] last_sum;
  logic        seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_valid && !out_stall) begin
      seen     <= 1'b1;
      last_sum <= hit_total + miss_total;
    end
  end

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(hit) &&
      $stable(wrote_back) && $stable(hit_total) && $stable(miss_total))
    else $error("stalled result changed");

  // A write-back only happens on a miss.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && wrote_back |-> !hit)
    else $error("write-back reported on a hit");

  // Each result counts exactly one hit or one miss.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && seen |-> hit_total + miss_total == last_sum + 32'd1)
    else $error("counters did not advance by one");

  // The cache works one access at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an access is in flight");

endmodule

bind set_assoc_writeback_cache sawc_checker #(.ADDR_BITS(ADDR_BITS)) u_sawc_checker (.*);

[dv/tb_set_assoc_writeback_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_writeback_cache
// Self-checking testbench of the set-associative write-back cache. A
// behavioral copy of the cache and its main memory predicts every result
// beat, and a scoreboard compares the beats field by field. The run walks
// several geometries, including out-of-range register values that saturate,
// with directed accesses followed by random accesses aimed at hits, set
// conflicts and dirty evictions, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_set_assoc_writeback_cache;

  localparam int ITEMS_PER_PHASE = 130;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int NUM_LINES       = 4096;
  localparam int DATA_BYTES      = 16384;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        hit;
    logic        wrote_back;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = sawc_pkg::OP_READ;
  logic [15:0] address = '0;
  logic [7:0]  write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic        hit;
  logic        wrote_back;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = sawc_pkg::CFG_WAYS;
  logic [3:0]  cfg_data = '0;

  set_assoc_writeback_cache uut (.*);

  // Shadow copy of the cache state and its configuration.
  logic [15:0] line_tag [NUM_LINES];
  bit          line_valid [NUM_LINES];
  bit          line_dirty [NUM_LINES];
  logic [2:0]  line_age [NUM_LINES];
  logic [7:0]  cache_bytes [DATA_BYTES];
  logic [7:0]  mem_bytes [65536];
  logic [31:0] hit_count, miss_count;
  logic [1:0]  ways_reg;
  logic [2:0]  block_reg;
  logic [3:0]  capacity_reg;

  access_t  pending_accesses[$];
  outcome_t expected_outcomes[$];
  int       errors = 0;
  int       cycles = 0;
  int       beats_checked = 0;
  int       writebacks_seen = 0;
  bit       beat_taken = 1'b0;

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Effective geometry after saturation of the register values.
  function automatic void effective_geometry(output int wl, output int bl, output int cl);
    wl = ways_reg;
    bl = block_reg;
    cl = capacity_reg;
    while (wl > 0 && (1 << wl) > 8) wl--;
    if (bl < 2) bl = 2;
    if (bl > sawc_pkg::BLOCK_LOG2_MAX) bl = sawc_pkg::BLOCK_LOG2_MAX;
    if (cl < sawc_pkg::CAPACITY_LOG2_MIN) cl = sawc_pkg::CAPACITY_LOG2_MIN;
    if (cl < bl + wl) cl = bl + wl;
    if (cl > 14) cl = 14;
    while (bl + wl > cl && wl > 0) wl--;
    while (bl + wl > cl && bl > 0) bl--;
  endfunction

  function automatic void invalidate_lines();
    for (int i = 0; i < NUM_LINES; i++) begin
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_age[i] = '0;
    end
  endfunction

  // Computes the outcome of one access and updates the shadow state.
  task automatic predict_access(input access_t acc);
    int wl, bl, cl, sl, ways, bsize, offs, set_idx, base, way, li, dbase, di;
    int best, old_age;
    logic [15:0] tag, vaddr, faddr;
    bit is_hit, found, was_valid, wb;
    outcome_t res;
    effective_geometry(wl, bl, cl);
    sl = cl - bl - wl;
    ways = 1 << wl;
    bsize = 1 << bl;
    offs = acc.address & (bsize - 1);
    set_idx = (acc.address >> bl) & ((1 << sl) - 1);
    tag = acc.address >> (bl + sl);
    base = set_idx << wl;
    is_hit = 1'b0;
    wb = 1'b0;
    way = 0;
    was_valid = 1'b1;
    for (int i = 0; i < ways; i++) begin
      if (!is_hit && line_valid[base + i] && line_tag[base + i] == tag) begin
        is_hit = 1'b1;
        way = i;
      end
    end
    if (is_hit) begin
      hit_count++;
    end else begin
      miss_count++;
      // Victim: lowest invalid way, else the oldest way with the lowest index.
      found = 1'b0;
      best = 0;
      for (int i = 0; i < ways; i++) begin
        if (!found) begin
          if (!line_valid[base + i]) begin
            way = i;
            found = 1'b1;
          end else if (line_age[base + i] > best) begin
            best = line_age[base + i];
          end
        end
      end
      if (!found) begin
        for (int i = ways - 1; i >= 0; i--)
          if (line_age[base + i] == best) way = i;
      end
      li = base + way;
      dbase = (li << bl) % DATA_BYTES;
      was_valid = line_valid[li];
      if (was_valid && line_dirty[li]) begin
        vaddr = 16'((line_tag[li] << (bl + sl)) | (set_idx << bl));
        for (int k = 0; k < bsize; k++)
          mem_bytes[16'(vaddr + k)] = cache_bytes[(dbase + k) % DATA_BYTES];
        wb = 1'b1;
      end
      faddr = acc.address & ~16'(bsize - 1);
      for (int k = 0; k < bsize; k++)
        cache_bytes[(dbase + k) % DATA_BYTES] = mem_bytes[16'(faddr + k)];
      line_tag[li] = tag;
      line_valid[li] = 1'b1;
      line_dirty[li] = 1'b0;
    end
    li = base + way;
    di = ((li << bl) + offs) % DATA_BYTES;
    // Recency update: the accessed way becomes the youngest.
    old_age = was_valid ? line_age[li] : ways;
    for (int i = 0; i < ways; i++)
      if (i != way && line_valid[base + i] && line_age[base + i] < old_age)
        line_age[base + i]++;
    line_age[li] = '0;
    if (acc.op == sawc_pkg::OP_WRITE) begin
      cache_bytes[di] = acc.write_data;
      line_dirty[li] = 1'b1;
    end
    res.read_data = cache_bytes[di];
    res.hit = is_hit;
    res.wrote_back = wb;
    res.hit_total = hit_count;
    res.miss_total = miss_count;
    expected_outcomes.push_back(res);
  endtask

  // Input beat capture, output checking and the cycle limit.
  always @(posedge clk) begin
    outcome_t exp_res;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
    if (!rst && in_valid && !in_stall) begin
      predict_access('{op: op, address: address, write_data: write_data});
      beat_taken = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $error("Result beat with no access outstanding");
        errors++;
      end else begin
        exp_res = expected_outcomes.pop_front();
        beats_checked++;
        if (wrote_back) writebacks_seen++;
        if (read_data !== exp_res.read_data) begin
          $error("read_data expected %0h actual %0h", exp_res.read_data, read_data);
          errors++;
        end
        if (hit !== exp_res.hit) begin
          $error("hit expected %0b actual %0b", exp_res.hit, hit);
          errors++;
        end
        if (wrote_back !== exp_res.wrote_back) begin
          $error("wrote_back expected %0b actual %0b", exp_res.wrote_back, wrote_back);
          errors++;
        end
        if (hit_total !== exp_res.hit_total) begin
          $error("hit_total expected %0d actual %0d", exp_res.hit_total, hit_total);
          errors++;
        end
        if (miss_total !== exp_res.miss_total) begin
          $error("miss_total expected %0d actual %0d", exp_res.miss_total, miss_total);
          errors++;
        end
      end
    end
  end

  // Access driver: bursts of beats separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    access_t acc;
    if (in_valid && !beat_taken) begin
      // Hold the stalled beat.
    end else begin
      beat_taken = 1'b0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0 || pending_accesses.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        acc = pending_accesses.pop_front();
        op <= acc.op;
        address <= acc.address;
        write_data <= acc.write_data;
        in_valid <= 1'b1;
        burst_left--;
      end
    end
  end

  // Result stall pattern: free-running, random, or long stretches.
  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 97 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom % 3 == 0);
      default: out_stall <= (cycles % 23) < 15;
    endcase
  end

  task automatic add_access(input logic o, input logic [15:0] a, input logic [7:0] d);
    pending_accesses.push_back('{op: o, address: a, write_data: d});
  endtask

  // Waits until every queued access has produced its result.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_accesses.size() != 0 || expected_outcomes.size() != 0 || in_valid);
    repeat (20) @(negedge clk);
  endtask

  // One register write, followed by a wait with the write port idle.
  task automatic write_register(input logic [1:0] idx, input logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      sawc_pkg::CFG_WAYS:  ways_reg = val[1:0];
      sawc_pkg::CFG_BLOCK: block_reg = val[2:0];
      default:             capacity_reg = val;
    endcase
    invalidate_lines();
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Random accesses: hot windows, set conflicts, the top of memory, noise.
  task automatic add_random_accesses(input int count);
    int wl, bl, cl, sl, hot_set, tag_bits;
    logic [15:0] hot_base, tag_base, a, t;
    effective_geometry(wl, bl, cl);
    sl = cl - bl - wl;
    tag_bits = 16 - bl - sl;
    hot_base = 16'($urandom);
    hot_set = $urandom_range(0, (1 << sl) - 1);
    tag_base = 16'($urandom);
    for (int n = 0; n < count; n++) begin
      if ($urandom % 16 == 0) begin
        hot_base = 16'($urandom);
        hot_set = $urandom_range(0, (1 << sl) - 1);
      end
      case ($urandom % 8) inside
        0: a = 16'($urandom);
        [1:3]: a = 16'(hot_base + $urandom_range(0, (2 << cl) - 1));
        [4:6]: begin
          t = 16'((tag_base + $urandom_range(0, (1 << wl) + 1)) & ((1 << tag_bits) - 1));
          a = 16'((t << (bl + sl)) | (hot_set << bl) | $urandom_range(0, (1 << bl) - 1));
        end
        default: a = 16'hFF00 | 16'($urandom_range(0, 255));
      endcase
      add_access($urandom % 2 ? sawc_pkg::OP_WRITE : sawc_pkg::OP_READ, a, 8'($urandom));
    end
  endtask

  // Register settings per phase: ways, block, capacity.
  logic [3:0] phase_cfg [8][3] = '{
    '{4'd0, 4'd5, 4'd12}, '{4'd3, 4'd2, 4'd8},  '{4'd3, 4'd6, 4'd14},
    '{4'd2, 4'd0, 4'd3},  '{4'd1, 4'd7, 4'd15}, '{4'd3, 4'd6, 4'd8},
    '{4'd0, 4'd2, 4'd14}, '{4'd2, 4'd4, 4'd10}
  };

  // Sequence of phases.
  initial begin
    for (int i = 0; i < 65536; i++) mem_bytes[i] = '0;
    for (int i = 0; i < DATA_BYTES; i++) cache_bytes[i] = '0;
    for (int i = 0; i < NUM_LINES; i++) line_tag[i] = '0;
    invalidate_lines();
    hit_count = '0;
    miss_count = '0;
    ways_reg = sawc_pkg::WAYS_LOG2_RST;
    block_reg = sawc_pkg::BLOCK_LOG2_RST;
    capacity_reg = sawc_pkg::CAPACITY_LOG2_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset geometry (direct mapped, 32-byte blocks).
    add_access(sawc_pkg::OP_WRITE, 16'h0000, 8'hFF);
    add_access(sawc_pkg::OP_READ,  16'h0000, 8'h00);
    add_access(sawc_pkg::OP_WRITE, 16'hFFFF, 8'h00);
    add_access(sawc_pkg::OP_READ,  16'hFFFF, 8'hFF);
    add_access(sawc_pkg::OP_READ,  16'h0001, 8'hA5);
    add_access(sawc_pkg::OP_WRITE, 16'h001F, 8'h5A);
    // Same set, new tag: the dirty block goes back to memory.
    add_access(sawc_pkg::OP_READ,  16'h1000, 8'h00);
    add_access(sawc_pkg::OP_READ,  16'h0000, 8'h00);
    add_access(sawc_pkg::OP_READ,  16'h001F, 8'h00);
    add_access(sawc_pkg::OP_WRITE, 16'h8FE0, 8'h81);
    add_access(sawc_pkg::OP_READ,  16'h0FE0, 8'h00);
    add_access(sawc_pkg::OP_READ,  16'h8FE0, 8'h00);
    add_access(sawc_pkg::OP_READ,  16'h7FFF, 8'h00);
    add_access(sawc_pkg::OP_WRITE, 16'hAAAA, 8'h55);
    add_access(sawc_pkg::OP_WRITE, 16'h5555, 8'hAA);
    add_access(sawc_pkg::OP_READ,  16'hAAAA, 8'h00);
    add_access(sawc_pkg::OP_READ,  16'h5555, 8'h00);
    wait_drained();
    add_random_accesses(ITEMS_PER_PHASE - 17);
    wait_drained();

    for (int p = 1; p < 8; p++) begin
      write_register(sawc_pkg::CFG_WAYS, phase_cfg[p][0]);
      write_register(sawc_pkg::CFG_BLOCK, phase_cfg[p][1]);
      write_register(sawc_pkg::CFG_CAPACITY, phase_cfg[p][2]);
      add_random_accesses(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      $error("%0d results never arrived", expected_outcomes.size());
      errors++;
    end
    $display("Checked %0d result beats over 8 geometries: %0d hits, %0d misses, %0d write-backs.",
             beats_checked, hit_count, miss_count, writebacks_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
